// ----- rtl/core/interval_jitter_statistics_core_defines.svh -----
// assertion macros for the interval jitter statistics core
`ifndef INTERVAL_JITTER_STATISTICS_CORE_DEFINES_SVH
`define INTERVAL_JITTER_STATISTICS_CORE_DEFINES_SVH

// same-cycle implication
`define IJS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define IJS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/ijs_pkg.sv -----
package ijs_pkg;

  localparam int SQ_W      = 64;
  localparam int Q_W       = 36;
  localparam int PM_W      = 16;
  localparam int WC_W      = 16;
  localparam int NP_W      = 24;
  localparam int K_W       = 20;
  localparam int MIN_W     = 32;
  localparam int OUT_CNT_W = 16;

  localparam logic [MIN_W-1:0] INIT_MIN = 32'd1000000000;
  localparam logic [K_W-1:0]   K_SCALE  = 20'd1000000;
  localparam logic [WC_W-1:0]  WC_RESET = 16'd1000;
  localparam logic [NP_W-1:0]  NP_RESET = 24'd10000;
  localparam logic [Q_W-1:0]   Q_MAX    = '1;
  localparam logic [PM_W-1:0]  PM_MAX   = '1;

  typedef enum logic {
    REG_WINDOW_COUNT,
    REG_NOMINAL_PERIOD
  } reg_idx_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_SAMPLE,
    OP_ACC,
    OP_MUL_NSQ,
    OP_MUL_SS,
    OP_VAR,
    OP_MUL_VK,
    OP_SQRT_STD,
    OP_SQRT_PM,
    OP_MUL_NP,
    OP_DIV_MEAN,
    OP_DIV_STD,
    OP_DIV_PM,
    OP_STEP_MUL,
    OP_STEP_SQRT,
    OP_STEP_DIV,
    OP_EMIT
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ACC,
    S_NSQ,
    S_NSQ_RUN,
    S_SS,
    S_SS_RUN,
    S_VAR,
    S_VK,
    S_VK_RUN,
    S_SQ1,
    S_SQ1_RUN,
    S_SQ2,
    S_SQ2_RUN,
    S_NP,
    S_NP_RUN,
    S_DV1,
    S_DV1_RUN,
    S_DV2,
    S_DV2_RUN,
    S_DV3,
    S_DV3_RUN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic started;
    logic win_full;
    logic mul_done;
    logic iter_done;
  } dp_status_t;

endpackage

// ----- rtl/core/interval_jitter_statistics_core.sv -----
// Gathers gap statistics over a window of timer timestamps. A sample that
// does not close a window is taken and then accumulated, with further
// samples stalled meanwhile; the very first sample of a window is only
// recorded. The sample that closes the window starts a sequence on one
// shared shift-add multiplier, one two-bit-per-step square root unit and one
// bit-serial divider: the multiplier runs once per significant bit of its
// second operand (count, sum, 20, count), and at default widths the square
// root runs twice over 50 steps and the divider three times over 52 steps,
// after which the result waits in the output register while new samples are
// taken. A further window end waits until that result has transferred.
`include "interval_jitter_statistics_core_defines.svh"

module interval_jitter_statistics_core import ijs_pkg::*; #(
  parameter int TIME_WIDTH  = 48,
  parameter int GAP_WIDTH   = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [TIME_WIDTH-1:0] in_timestamp_us,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [15:0]           out_gap_count,
  output logic [31:0]           out_min_gap,
  output logic [31:0]           out_max_gap,
  output logic [35:0]           out_mean_q4,
  output logic [35:0]           out_std_dev_q4,
  output logic [15:0]           out_deviation_permille,
  output logic                  out_overflow,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [WC_W-1:0] wc_r;
  logic [NP_W-1:0] np_r;
  dp_status_t      sts;
  op_t             op;
  reg_idx_t        reg_sel;

  assign reg_sel = reg_idx_t'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r <= WC_RESET;
      np_r <= NP_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_WINDOW_COUNT:   wc_r <= pwdata[WC_W-1:0];
        REG_NOMINAL_PERIOD: np_r <= pwdata[NP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_WINDOW_COUNT:   prdata = 32'(wc_r);
      REG_NOMINAL_PERIOD: prdata = 32'(np_r);
      default:            prdata = '0;
    endcase
  end

  ijs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .op        (op)
  );

  ijs_datapath #(
    .TIME_WIDTH  (TIME_WIDTH),
    .GAP_WIDTH   (GAP_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .op                 (op),
    .timestamp          (in_timestamp_us),
    .window_count       (wc_r),
    .period             (np_r),
    .sts                (sts),
    .gap_count          (out_gap_count),
    .min_gap            (out_min_gap),
    .max_gap            (out_max_gap),
    .mean_q4            (out_mean_q4),
    .std_dev_q4         (out_std_dev_q4),
    .deviation_permille (out_deviation_permille),
    .overflow           (out_overflow)
  );

  `IJS_ASSERT_NXT(a_gap_busy, in_valid && !in_stall && sts.started, in_stall, "gap transfer not followed by accumulate")
  `IJS_ASSERT_IMP(a_emit_closes, $rose(out_valid), !sts.started, "window still open after result")
  `IJS_ASSERT_IMP(a_min_bound, out_valid, out_min_gap <= INIT_MIN, "minimum above initial value")

endmodule

// ----- rtl/core/ijs_ctrl.sv -----
module ijs_ctrl import ijs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t sts,
  output op_t        op
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    emit      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op = OP_SAMPLE;
          if (sts.started) state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        op        = OP_ACC;
        state_nxt = sts.win_full ? S_NSQ : S_IDLE;
      end
      S_NSQ: begin
        op        = OP_MUL_NSQ;
        state_nxt = S_NSQ_RUN;
      end
      S_NSQ_RUN: begin
        if (sts.mul_done) state_nxt = S_SS;
        else op = OP_STEP_MUL;
      end
      S_SS: begin
        op        = OP_MUL_SS;
        state_nxt = S_SS_RUN;
      end
      S_SS_RUN: begin
        if (sts.mul_done) state_nxt = S_VAR;
        else op = OP_STEP_MUL;
      end
      S_VAR: begin
        op        = OP_VAR;
        state_nxt = S_VK;
      end
      S_VK: begin
        op        = OP_MUL_VK;
        state_nxt = S_VK_RUN;
      end
      S_VK_RUN: begin
        if (sts.mul_done) state_nxt = S_SQ1;
        else op = OP_STEP_MUL;
      end
      S_SQ1: begin
        op        = OP_SQRT_STD;
        state_nxt = S_SQ1_RUN;
      end
      S_SQ1_RUN: begin
        if (sts.iter_done) state_nxt = S_SQ2;
        else op = OP_STEP_SQRT;
      end
      S_SQ2: begin
        op        = OP_SQRT_PM;
        state_nxt = S_SQ2_RUN;
      end
      S_SQ2_RUN: begin
        if (sts.iter_done) state_nxt = S_NP;
        else op = OP_STEP_SQRT;
      end
      S_NP: begin
        op        = OP_MUL_NP;
        state_nxt = S_NP_RUN;
      end
      S_NP_RUN: begin
        if (sts.mul_done) state_nxt = S_DV1;
        else op = OP_STEP_MUL;
      end
      S_DV1: begin
        op        = OP_DIV_MEAN;
        state_nxt = S_DV1_RUN;
      end
      S_DV1_RUN: begin
        if (sts.iter_done) state_nxt = S_DV2;
        else op = OP_STEP_DIV;
      end
      S_DV2: begin
        op        = OP_DIV_STD;
        state_nxt = S_DV2_RUN;
      end
      S_DV2_RUN: begin
        if (sts.iter_done) state_nxt = S_DV3;
        else op = OP_STEP_DIV;
      end
      S_DV3: begin
        op        = OP_DIV_PM;
        state_nxt = S_DV3_RUN;
      end
      S_DV3_RUN: begin
        if (sts.iter_done) state_nxt = S_EMIT;
        else op = OP_STEP_DIV;
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          op        = OP_EMIT;
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = (out_valid_r && out_stall) || emit;
  assign out_valid     = out_valid_r;
  assign in_stall      = (state_r != S_IDLE);

endmodule

// ----- rtl/core/ijs_datapath.sv -----
module ijs_datapath import ijs_pkg::*; #(
  parameter int TIME_WIDTH  = 48,
  parameter int GAP_WIDTH   = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  op_t                   op,
  input  logic [TIME_WIDTH-1:0] timestamp,
  input  logic [WC_W-1:0]       window_count,
  input  logic [NP_W-1:0]       period,
  output dp_status_t            sts,
  output logic [OUT_CNT_W-1:0]  gap_count,
  output logic [MIN_W-1:0]      min_gap,
  output logic [MIN_W-1:0]      max_gap,
  output logic [Q_W-1:0]        mean_q4,
  output logic [Q_W-1:0]        std_dev_q4,
  output logic [PM_W-1:0]       deviation_permille,
  output logic                  overflow
);

  localparam int NSQ_W  = SQ_W + COUNT_WIDTH;
  localparam int SS_W   = 2 * TIME_WIDTH;
  localparam int PRD_W  = (SS_W > NSQ_W + K_W) ? SS_W : NSQ_W + K_W;
  localparam int RAD_W  = PRD_W + (PRD_W % 2);
  localparam int RT_W   = RAD_W / 2;
  localparam int DS_W   = COUNT_WIDTH + NP_W;
  localparam int DD_W   = (TIME_WIDTH + 4 > RT_W) ? TIME_WIDTH + 4 : RT_W;
  localparam int ITER_W = $clog2(DD_W + 1);
  localparam int CMP_W  = (COUNT_WIDTH > WC_W) ? COUNT_WIDTH : WC_W;
  localparam int SUM_EW = TIME_WIDTH + 1;
  localparam int SQ_EW  = SQ_W + 1;
  localparam logic [TIME_WIDTH-1:0] GAP_MAX = TIME_WIDTH'({GAP_WIDTH{1'b1}});

  logic                    started_r;
  logic [TIME_WIDTH-1:0]   latest_r, prev_r, sum_r;
  logic [MIN_W-1:0]        min_r, max_r;
  logic [SQ_W-1:0]         sqsum_r;
  logic [COUNT_WIDTH-1:0]  cnt_r;
  logic                    sat_r;
  logic [GAP_WIDTH-1:0]    gap_r;
  logic [PRD_W-1:0]        mul_a_r, prod_r, vk_r;
  logic [TIME_WIDTH-1:0]   mul_b_r;
  logic [NSQ_W-1:0]        p1_r, var_r;
  logic [RT_W-1:0]         s1_r, s2_r, root_r;
  logic [RAD_W-1:0]        rad_r;
  logic [RT_W+1:0]         srem_r;
  logic [DS_W-1:0]         dsr_np_r, dsr_r;
  logic [DD_W-1:0]         dq_r;
  logic [DS_W:0]           drem_r;
  logic [Q_W-1:0]          mean_r, std_r;
  logic [ITER_W-1:0]       iter_r;
  logic [OUT_CNT_W-1:0]    o_cnt_r;
  logic [MIN_W-1:0]        o_min_r, o_max_r;
  logic [Q_W-1:0]          o_mean_r, o_std_r;
  logic [PM_W-1:0]         o_pm_r;
  logic                    o_ovf_r;

  logic [TIME_WIDTH-1:0]   ts_clamp, gap_full;
  logic                    gap_big;
  logic [GAP_WIDTH-1:0]    gap_sat;
  logic [SUM_EW-1:0]       sum_ext;
  logic [2*GAP_WIDTH-1:0]  sq_g;
  logic [SQ_EW-1:0]        sqsum_ext;
  logic [COUNT_WIDTH-1:0]  cnt_inc;
  logic [PRD_W-1:0]        mul_sum, p1_ext, var_diff;
  logic                    var_ge;
  logic [RT_W+1:0]         srem_sh, s_trial;
  logic                    s_ge;
  logic [DS_W:0]           drem_sh;
  logic                    d_ge;
  logic [Q_W-1:0]          q36;
  logic [PM_W-1:0]         pm16;

  assign ts_clamp  = (timestamp < latest_r) ? latest_r : timestamp;
  assign gap_full  = ts_clamp - prev_r;
  assign gap_big   = gap_full > GAP_MAX;
  assign gap_sat   = gap_big ? '1 : gap_full[GAP_WIDTH-1:0];
  assign sum_ext   = {1'b0, sum_r} + SUM_EW'(gap_r);
  assign sq_g      = gap_r * gap_r;
  assign sqsum_ext = {1'b0, sqsum_r} + SQ_EW'(sq_g);
  assign cnt_inc   = cnt_r + COUNT_WIDTH'(1);
  assign mul_sum   = prod_r + (mul_b_r[0] ? mul_a_r : '0);
  assign p1_ext    = PRD_W'(p1_r);
  assign var_ge    = p1_ext >= prod_r;
  assign var_diff  = p1_ext - prod_r;
  assign srem_sh   = {srem_r[RT_W-1:0], rad_r[RAD_W-1 -: 2]};
  assign s_trial   = {root_r, 2'b01};
  assign s_ge      = srem_sh >= s_trial;
  assign drem_sh   = {drem_r[DS_W-1:0], dq_r[DD_W-1]};
  assign d_ge      = drem_sh >= {1'b0, dsr_r};
  assign q36       = (dq_r > DD_W'(Q_MAX)) ? Q_MAX : dq_r[Q_W-1:0];
  assign pm16      = (dq_r > DD_W'(PM_MAX)) ? PM_MAX : dq_r[PM_W-1:0];

  assign sts.started   = started_r;
  assign sts.win_full  = CMP_W'(cnt_inc) >= CMP_W'(window_count);
  assign sts.mul_done  = (mul_b_r == '0);
  assign sts.iter_done = (iter_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      latest_r  <= '0;
    end else begin
      if (op == OP_SAMPLE) begin
        latest_r <= ts_clamp;
        if (!started_r) started_r <= 1'b1;
      end else if (op == OP_EMIT) begin
        started_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      OP_SAMPLE: begin
        prev_r <= ts_clamp;
        if (!started_r) begin
          min_r   <= INIT_MIN;
          max_r   <= '0;
          sum_r   <= '0;
          sqsum_r <= '0;
          cnt_r   <= '0;
          sat_r   <= 1'b0;
        end else begin
          gap_r <= gap_sat;
          if (gap_big) sat_r <= 1'b1;
        end
      end
      OP_ACC: begin
        sum_r   <= sum_ext[TIME_WIDTH] ? '1 : sum_ext[TIME_WIDTH-1:0];
        sqsum_r <= sqsum_ext[SQ_W] ? '1 : sqsum_ext[SQ_W-1:0];
        sat_r   <= sat_r | sum_ext[TIME_WIDTH] | sqsum_ext[SQ_W];
        cnt_r   <= cnt_inc;
        if (MIN_W'(gap_r) > max_r) max_r <= MIN_W'(gap_r);
        if (MIN_W'(gap_r) < min_r) min_r <= MIN_W'(gap_r);
      end
      OP_MUL_NSQ: begin
        mul_a_r <= PRD_W'(sqsum_r);
        mul_b_r <= TIME_WIDTH'(cnt_r);
        prod_r  <= '0;
      end
      OP_MUL_SS: begin
        p1_r    <= prod_r[NSQ_W-1:0];
        mul_a_r <= PRD_W'(sum_r);
        mul_b_r <= sum_r;
        prod_r  <= '0;
      end
      OP_VAR: begin
        var_r <= var_ge ? var_diff[NSQ_W-1:0] : '0;
      end
      OP_MUL_VK: begin
        mul_a_r <= PRD_W'(var_r);
        mul_b_r <= TIME_WIDTH'(K_SCALE);
        prod_r  <= '0;
      end
      OP_SQRT_STD: begin
        vk_r   <= prod_r;
        rad_r  <= RAD_W'({var_r, 8'h00});
        srem_r <= '0;
        root_r <= '0;
        iter_r <= ITER_W'(RT_W);
      end
      OP_SQRT_PM: begin
        s1_r   <= root_r;
        rad_r  <= RAD_W'(vk_r);
        srem_r <= '0;
        root_r <= '0;
        iter_r <= ITER_W'(RT_W);
      end
      OP_MUL_NP: begin
        s2_r    <= root_r;
        mul_a_r <= PRD_W'(period);
        mul_b_r <= TIME_WIDTH'(cnt_r);
        prod_r  <= '0;
      end
      OP_DIV_MEAN: begin
        dsr_np_r <= prod_r[DS_W-1:0];
        dq_r     <= DD_W'({sum_r, 4'h0});
        dsr_r    <= DS_W'(cnt_r);
        drem_r   <= '0;
        iter_r   <= ITER_W'(DD_W);
      end
      OP_DIV_STD: begin
        mean_r <= q36;
        dq_r   <= DD_W'(s1_r);
        dsr_r  <= DS_W'(cnt_r);
        drem_r <= '0;
        iter_r <= ITER_W'(DD_W);
      end
      OP_DIV_PM: begin
        std_r  <= q36;
        dq_r   <= DD_W'(s2_r);
        dsr_r  <= dsr_np_r;
        drem_r <= '0;
        iter_r <= ITER_W'(DD_W);
      end
      OP_STEP_MUL: begin
        prod_r  <= mul_sum;
        mul_a_r <= mul_a_r << 1;
        mul_b_r <= mul_b_r >> 1;
      end
      OP_STEP_SQRT: begin
        rad_r  <= rad_r << 2;
        srem_r <= s_ge ? srem_sh - s_trial : srem_sh;
        root_r <= {root_r[RT_W-2:0], s_ge};
        iter_r <= iter_r - ITER_W'(1);
      end
      OP_STEP_DIV: begin
        drem_r <= d_ge ? drem_sh - {1'b0, dsr_r} : drem_sh;
        dq_r   <= {dq_r[DD_W-2:0], d_ge};
        iter_r <= iter_r - ITER_W'(1);
      end
      OP_EMIT: begin
        o_cnt_r  <= OUT_CNT_W'(cnt_r);
        o_min_r  <= min_r;
        o_max_r  <= max_r;
        o_mean_r <= mean_r;
        o_std_r  <= std_r;
        o_pm_r   <= pm16;
        o_ovf_r  <= sat_r;
      end
      OP_NONE: begin
      end
      default: begin
      end
    endcase
  end

  assign gap_count          = o_cnt_r;
  assign min_gap            = o_min_r;
  assign max_gap            = o_max_r;
  assign mean_q4            = o_mean_r;
  assign std_dev_q4         = o_std_r;
  assign deviation_permille = o_pm_r;
  assign overflow           = o_ovf_r;

endmodule

// ----- tb/testbench.sv -----
module testbench import ijs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [15:0] gap_count;
    logic [31:0] min_gap;
    logic [31:0] max_gap;
    logic [35:0] mean_q4;
    logic [35:0] std_dev_q4;
    logic [15:0] deviation_permille;
    logic        overflow;
  } jitter_stats_t;

  class jitter_scoreboard;
    logic [15:0]   win_len;
    logic [23:0]   period_us;
    bit            in_window;
    logic [47:0]   prev_ts;
    logic [47:0]   last_ts;
    logic [31:0]   min_gap;
    logic [31:0]   max_gap;
    logic [47:0]   sum_gap;
    logic [63:0]   sum_sq;
    logic [15:0]   n_gaps;
    bit            sat;
    jitter_stats_t pending[$];
    int            errors;

    function void reset_state();
      win_len = WC_RESET;
      period_us = NP_RESET;
      in_window = 0;
      prev_ts = '0;
      last_ts = '0;
      min_gap = INIT_MIN;
      max_gap = '0;
      sum_gap = '0;
      sum_sq = '0;
      n_gaps = '0;
      sat = 0;
      errors = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] val);
      if (idx == REG_WINDOW_COUNT) win_len = val[15:0];
      else period_us = val[23:0];
    endfunction

    function logic [63:0] root(logic [127:0] x);
      logic [63:0] r;
      logic [127:0] c;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
        c = {64'd0, r | (64'd1 << b)};
        if (c * c <= x) r = c[63:0];
      end
      return r;
    endfunction

    function void note_sample(logic [47:0] ts);
      logic [63:0] gap, sq, n, v;
      logic [127:0] var_num, a, b;
      jitter_stats_t e;
      if (ts < last_ts) ts = last_ts;
      last_ts = ts;
      if (!in_window) begin
        in_window = 1;
        prev_ts = ts;
        min_gap = INIT_MIN;
        max_gap = '0;
        sum_gap = '0;
        sum_sq = '0;
        n_gaps = '0;
        sat = 0;
        return;
      end
      gap = {16'd0, ts - prev_ts};
      prev_ts = ts;
      if (gap > 64'hFFFF_FFFF) begin
        gap = 64'hFFFF_FFFF;
        sat = 1;
      end
      if (gap > {16'd0, 48'hFFFF_FFFF_FFFF - sum_gap}) begin
        sum_gap = '1;
        sat = 1;
      end else sum_gap = sum_gap + gap[47:0];
      sq = gap * gap;
      if (sq > 64'hFFFF_FFFF_FFFF_FFFF - sum_sq) begin
        sum_sq = '1;
        sat = 1;
      end else sum_sq = sum_sq + sq;
      n_gaps = n_gaps + 16'd1;
      if (gap[31:0] > max_gap) max_gap = gap[31:0];
      if (gap[31:0] < min_gap) min_gap = gap[31:0];
      if (n_gaps < win_len) return;
      n = {48'd0, n_gaps};
      v = {12'd0, sum_gap, 4'd0} / n;
      e.mean_q4 = (v > {28'd0, Q_MAX}) ? Q_MAX : v[35:0];
      a = {64'd0, n} * {64'd0, sum_sq};
      b = {80'd0, sum_gap} * {80'd0, sum_gap};
      var_num = (b <= a) ? a - b : '0;
      v = root(var_num << 8) / n;
      e.std_dev_q4 = (v > {28'd0, Q_MAX}) ? Q_MAX : v[35:0];
      if (period_us == '0) e.deviation_permille = PM_MAX;
      else begin
        v = root(var_num * 128'd1000000) / (n * {40'd0, period_us});
        e.deviation_permille = (v > 64'd65535) ? PM_MAX : v[15:0];
      end
      e.gap_count = n_gaps;
      e.min_gap = min_gap;
      e.max_gap = max_gap;
      e.overflow = sat;
      pending.push_back(e);
      in_window = 0;
    endfunction

    function void check_result(jitter_stats_t got);
      jitter_stats_t e;
      if (pending.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.gap_count !== e.gap_count) begin
        $error("gap_count exp %0d got %0d", e.gap_count, got.gap_count); errors++;
      end
      if (got.min_gap !== e.min_gap) begin
        $error("min_gap exp %0d got %0d", e.min_gap, got.min_gap); errors++;
      end
      if (got.max_gap !== e.max_gap) begin
        $error("max_gap exp %0d got %0d", e.max_gap, got.max_gap); errors++;
      end
      if (got.mean_q4 !== e.mean_q4) begin
        $error("mean_q4 exp %0d got %0d", e.mean_q4, got.mean_q4); errors++;
      end
      if (got.std_dev_q4 !== e.std_dev_q4) begin
        $error("std_dev_q4 exp %0d got %0d", e.std_dev_q4, got.std_dev_q4); errors++;
      end
      if (got.deviation_permille !== e.deviation_permille) begin
        $error("deviation_permille exp %0d got %0d", e.deviation_permille,
               got.deviation_permille);
        errors++;
      end
      if (got.overflow !== e.overflow) begin
        $error("overflow exp %0d got %0d", e.overflow, got.overflow); errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [47:0] in_timestamp_us = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [15:0] out_gap_count;
  logic [31:0] out_min_gap;
  logic [31:0] out_max_gap;
  logic [35:0] out_mean_q4;
  logic [35:0] out_std_dev_q4;
  logic [15:0] out_deviation_permille;
  logic        out_overflow;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  jitter_scoreboard sb = new();
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_off = 0;
  int          quiet_cycles = 0;
  logic [63:0] now_us = '0;

  interval_jitter_statistics_core u_dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    jitter_stats_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.gap_count = out_gap_count;
      got.min_gap = out_min_gap;
      got.max_gap = out_max_gap;
      got.mean_q4 = out_mean_q4;
      got.std_dev_q4 = out_std_dev_q4;
      got.deviation_permille = out_deviation_permille;
      got.overflow = out_overflow;
      sb.check_result(got);
    end
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1;
    end else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("interval_jitter_statistics_core test failed");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    sb.set_reg(idx, val);
  endtask

  task automatic send(logic [47:0] ts);
    in_valid <= 1;
    in_timestamp_us <= ts;
    do @(posedge clk); while (in_stall);
    sb.note_sample(ts);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  function automatic logic [47:0] next_time();
    int r;
    logic [63:0] t;
    r = $urandom_range(99);
    if (r < 6) begin
      t = now_us - (now_us < 5000 ? now_us : 64'($urandom_range(5000)));
      return t[47:0];
    end
    if (r < 10) t = now_us;
    else if (r < 13) t = now_us + 64'hFFFF_FFF0 + $urandom_range(1 << 20);
    else if (r < 16) t = now_us + $urandom_range(32'h7FFF_FFFF);
    else t = now_us + $urandom_range(1100, 900);
    if (t > 64'hFFFF_FFFF_FFFF) t = 64'hFFFF_FFFF_FFFF;
    now_us = t;
    return t[47:0];
  endfunction

  task automatic run_phase(int items);
    repeat (items) send(next_time());
  endtask

  initial begin
    sb.reset_state();
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: normal window, backward and equal stamps, saturating gaps
    write_reg(REG_WINDOW_COUNT, 3);
    send(48'd100);
    send(48'd10100);
    send(48'd20100);
    send(48'd30000);
    send(48'd40000);
    send(48'd35000);
    send(48'd35000);
    send(48'd50000);
    send(48'd50000 + 48'h2_0000_0000);
    send(48'd50000 + 48'h4_0000_0000);
    send(48'd50000 + 48'h6_0000_0000);
    now_us = 64'd50000 + 64'h6_0000_0000;
    drain();
    write_reg(REG_WINDOW_COUNT, 1);
    write_reg(REG_NOMINAL_PERIOD, 1);
    send(now_us[47:0] + 48'd7);
    send(now_us[47:0] + 48'd7);
    now_us = now_us + 7;

    // random phases over several settings
    send_idle_pct = 14;
    recv_idle_pct = 88;
    drain();
    write_reg(REG_NOMINAL_PERIOD, 24'hFF_FFFF);
    write_reg(REG_WINDOW_COUNT, 2);
    run_phase(176);
    drain();
    write_reg(REG_WINDOW_COUNT, 5);
    write_reg(REG_NOMINAL_PERIOD, 1000);
    run_phase(176);
    drain();
    write_reg(REG_WINDOW_COUNT, 0);
    write_reg(REG_NOMINAL_PERIOD, 0);
    run_phase(176);

    send_idle_pct = 88;
    recv_idle_pct = 14;
    drain();
    write_reg(REG_WINDOW_COUNT, 1);
    write_reg(REG_NOMINAL_PERIOD, 10000);
    hold_off = 3000;
    run_phase(100);
    drain();
    write_reg(REG_WINDOW_COUNT, 16'hFFFF);
    write_reg(REG_NOMINAL_PERIOD, 7);
    run_phase(176);
    // shrink the window while gaps are already gathered
    drain();
    write_reg(REG_WINDOW_COUNT, 2);
    run_phase(176);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain();
    write_reg(REG_WINDOW_COUNT, 4);
    write_reg(REG_NOMINAL_PERIOD, 1);
    run_phase(176);
    drain();
    write_reg(REG_WINDOW_COUNT, 3);
    write_reg(REG_NOMINAL_PERIOD, 24'h12_3456);
    now_us = 64'hFFF0_0000_0000 | {32'd0, $urandom()};
    run_phase(176);
    send(48'hFFFF_FFFF_FFFF);
    send(48'hFFFF_FFFF_FFFF);
    send(48'd0);

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("interval_jitter_statistics_core test passed");
    else
      $display("interval_jitter_statistics_core test failed");
    $finish;
  end
endmodule
